[rtl/core/far_pkg.sv]
// ----------------------------------------------------------------------------
// far_pkg
// Shared types and constants of the four-register ALU machine: operation
// codes, payload widths and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package far_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int IMM_W          = 32;
  localparam int VAL_W          = 32;
  localparam int OP_W           = 3;
  localparam int REG_IDX_W      = 2;
  localparam int NUM_REGS       = 4;

  localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
  localparam logic [OP_W-1:0] OP_OUT  = 3'd1;
  localparam logic [OP_W-1:0] OP_MOVE = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd3;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd4;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd5;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd6;

  // Controller to datapath
  typedef struct packed {
    logic latch;      // capture instruction and read both operands
    logic wr_alu;     // write the load, move, add or subtract result
    logic start;      // load the iterative unit
    logic step;       // one multiply or divide iteration
    logic wr_iter;    // write the iterative result
    logic emit_read;  // load the result register with the register value
    logic emit_err;   // load the result register with the error result
  } far_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            b_zero;
    logic            iter_done;
    logic            out_free;
  } far_sts_t;

endpackage

[rtl/core/far_if.sv]
// ----------------------------------------------------------------------------
// far_in_if / far_out_if
// Valid/ready channels for instructions and results.
// ----------------------------------------------------------------------------
interface far_in_if
  import far_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [REG_IDX_W-1:0] dest_reg;
  logic [REG_IDX_W-1:0] src_reg;
  logic signed [IMM_W-1:0] immediate;

  modport source (output valid, operation, dest_reg, src_reg, immediate, input ready);
  modport sink   (input valid, operation, dest_reg, src_reg, immediate, output ready);
endinterface

interface far_out_if
  import far_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic                    status;

  modport source (output valid, read_value, status, input ready);
  modport sink   (input valid, read_value, status, output ready);
endinterface

[rtl/core/far_ctrl.sv]
// ----------------------------------------------------------------------------
// far_ctrl
// Instruction sequencer: accept, execute, iterate for multiply and divide.
// ----------------------------------------------------------------------------
module far_ctrl
  import far_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  far_sts_t sts,
  output far_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_ITER = 2'd2;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (sts.op)
          OP_LOAD, OP_MOVE, OP_ADD, OP_SUB: begin
            cmd.wr_alu = 1'b1;
            state_nxt  = ST_IDLE;
          end
          OP_OUT: begin
            // hold until the result register can take the transaction
            if (sts.out_free) begin
              cmd.emit_read = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          OP_MUL: begin
            cmd.start = 1'b1;
            state_nxt = ST_ITER;
          end
          OP_DIV: begin
            if (sts.b_zero) begin
              if (sts.out_free) begin
                cmd.emit_err = 1'b1;
                state_nxt    = ST_IDLE;
              end
            end else begin
              cmd.start = 1'b1;
              state_nxt = ST_ITER;
            end
          end
          default: begin
            // unknown operation: drop
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ITER: begin
        if (sts.iter_done) begin
          cmd.wr_iter = 1'b1;
          state_nxt   = ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("far_ctrl: second instruction accepted while one is in flight");

  a_iter_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ITER && sts.iter_done) |=> (state_r == ST_IDLE))
    else $error("far_ctrl: iteration did not finish after its last step");

  a_start_iter: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> (state_r == ST_EXEC && (sts.op == OP_MUL || sts.op == OP_DIV)))
    else $error("far_ctrl: iterative unit started outside multiply or divide");

endmodule

[rtl/core/far_dpath.sv]
// ----------------------------------------------------------------------------
// far_dpath
// Register file, operand registers, shared shift-add multiply and restoring
// divide unit, and the result register.
// ----------------------------------------------------------------------------
module far_dpath
  import far_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  far_cmd_t                cmd,
  output far_sts_t                sts,
  input  logic [OP_W-1:0]         in_operation,
  input  logic [REG_IDX_W-1:0]    in_dest_reg,
  input  logic [REG_IDX_W-1:0]    in_src_reg,
  input  logic signed [IMM_W-1:0] in_immediate,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_read_value,
  output logic                    out_status
);

  localparam int W  = DATA_WIDTH;
  localparam int CW = $clog2(W + 1);

  // register file: storage without reset, one valid bit per entry
  logic [W-1:0]          rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0]   rf_vld_r;

  logic [OP_W-1:0]       op_r;
  logic [REG_IDX_W-1:0]  dst_r;
  logic [W-1:0]          imm_r;
  logic [W-1:0]          a_raw_r, b_raw_r;
  logic                  a_vld_r, b_vld_r;
  logic [W-1:0]          a_val, b_val;

  // iterative unit
  logic [W-1:0]          x_r, y_r, acc_r;
  logic                  neg_r;
  logic [CW-1:0]         cnt_r;
  logic [W-1:0]          rem_sh;
  logic [W:0]            trial;
  logic [W-1:0]          iter_res;

  logic [W-1:0]          alu_res;
  logic                  wr_en;
  logic [W-1:0]          wr_data;

  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_value_r;
  logic                  out_status_r;

  assign a_val = a_vld_r ? a_raw_r : '0;
  assign b_val = b_vld_r ? b_raw_r : '0;

  always_comb begin
    unique case (op_r)
      OP_LOAD: alu_res = imm_r;
      OP_MOVE: alu_res = b_val;
      OP_ADD:  alu_res = a_val + b_val;
      OP_SUB:  alu_res = a_val - b_val;
      default: alu_res = '0;
    endcase
  end

  assign rem_sh   = {acc_r[W-2:0], y_r[W-1]};
  assign trial    = {1'b0, rem_sh} - {1'b0, x_r};
  assign iter_res = (op_r == OP_MUL) ? acc_r : (neg_r ? (W'(0) - y_r) : y_r);

  assign wr_en   = cmd.wr_alu || cmd.wr_iter;
  assign wr_data = cmd.wr_iter ? iter_res : alu_res;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rf_mem[dst_r] <= wr_data;
    end
    if (cmd.latch) begin
      a_raw_r <= rf_mem[in_dest_reg];
      b_raw_r <= rf_mem[in_src_reg];
      a_vld_r <= rf_vld_r[in_dest_reg];
      b_vld_r <= rf_vld_r[in_src_reg];
      op_r    <= in_operation;
      dst_r   <= in_dest_reg;
      imm_r   <= W'(in_immediate);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
    end else if (wr_en) begin
      rf_vld_r[dst_r] <= 1'b1;
    end
  end

  // multiply: x shifts left, y shifts right, acc sums
  // divide: x holds |b|, y shifts the dividend out and the quotient in
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
      cnt_r <= '0;
      if (op_r == OP_MUL) begin
        x_r   <= a_val;
        y_r   <= b_val;
        neg_r <= 1'b0;
      end else begin
        x_r   <= b_val[W-1] ? (W'(0) - b_val) : b_val;
        y_r   <= a_val[W-1] ? (W'(0) - a_val) : a_val;
        neg_r <= a_val[W-1] ^ b_val[W-1];
      end
    end else if (cmd.step) begin
      cnt_r <= cnt_r + CW'(1);
      if (op_r == OP_MUL) begin
        acc_r <= acc_r + (y_r[0] ? x_r : '0);
        x_r   <= {x_r[W-2:0], 1'b0};
        y_r   <= {1'b0, y_r[W-1:1]};
      end else if (!trial[W]) begin
        acc_r <= trial[W-1:0];
        y_r   <= {y_r[W-2:0], 1'b1};
      end else begin
        acc_r <= rem_sh;
        y_r   <= {y_r[W-2:0], 1'b0};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_read || cmd.emit_err) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_read) begin
      out_value_r  <= VAL_W'($signed(a_val));
      out_status_r <= 1'b0;
    end else if (cmd.emit_err) begin
      out_value_r  <= '0;
      out_status_r <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;
  assign out_status     = out_status_r;

  assign sts.op        = op_r;
  assign sts.b_zero    = (b_val == '0);
  assign sts.iter_done = (cnt_r == CW'(W));
  assign sts.out_free  = !out_valid_r || out_ready;

  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_err |=> (out_valid_r && out_status_r && out_value_r == '0))
    else $error("far_dpath: division by zero result malformed");

  a_read_status: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_read |=> (out_valid_r && !out_status_r))
    else $error("far_dpath: register read flagged as error");

  a_iter_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_iter |-> (cnt_r == CW'(W)))
    else $error("far_dpath: iterative result written before all steps");

endmodule

[rtl/core/four_register_alu_machine_core.sv]
// ----------------------------------------------------------------------------
// four_register_alu_machine_core
// Four-register ALU machine: one instruction per transaction on AX..DX.
// ----------------------------------------------------------------------------
// Each input transaction carries one instruction that acts on four signed
// DATA_WIDTH-bit registers (AX, BX, CX, DX), all zero after reset. Load,
// move, add and subtract are written back from the execute state; output
// and a divide by zero also wait there for the result register to drain.
// Multiply and divide go on from the execute state to the iterate state:
// one shared shift-add / restoring-divide unit retires one bit per cycle.
// Only one instruction is in flight at a time, but a result waiting in the
// output register does not block instructions that produce none. Results
// arrive in instruction order; the error result of a divide by zero reads
// as zero with status set and leaves the destination untouched.
// ----------------------------------------------------------------------------
module four_register_alu_machine_core
  import far_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  far_in_if.sink    in_ch,
  far_out_if.source out_ch
);

  far_cmd_t cmd;
  far_sts_t sts;

  // sequencer: accept, decode, iterate
  far_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // register file, arithmetic and the result register
  far_dpath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_operation   (in_ch.operation),
    .in_dest_reg    (in_ch.dest_reg),
    .in_src_reg     (in_ch.src_reg),
    .in_immediate   (in_ch.immediate),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_read_value (out_ch.read_value),
    .out_status     (out_ch.status)
  );

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for four_register_alu_machine_core.
// An in-bench mirror of the four-register ALU predicts every read-back.
// Instructions go in through the valid/ready input channel. Results come out
// through the output channel and are checked field by field, in order.
// Both sides stall at random. There is one long receiver hold-off and a few
// full drains of the sender.
// ----------------------------------------------------------------------------
module testbench
  import far_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Operation 7 has no package name; the block must ignore it
  localparam logic [OP_W-1:0] OP_NONE = 3'd7;

  localparam logic STATUS_READ     = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_AX = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BX = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CX = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_DX = 2'd3;

  localparam logic [VAL_W-1:0] MOST_NEGATIVE = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] MOST_POSITIVE = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] MINUS_ONE     = {VAL_W{1'b1}};

  localparam int RANDOM_ITEMS   = 1925;
  localparam int PHASE_LEN      = 320;
  localparam int LONG_HOLD      = 300;   // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES   = 80;    // a little over two divides
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction

  typedef struct packed {
    logic [OP_W-1:0]         operation;
    logic [REG_IDX_W-1:0]    dest_reg;
    logic [REG_IDX_W-1:0]    src_reg;
    logic signed [IMM_W-1:0] immediate;
  } instr_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic             status;
  } readback_t;

  // Mirror of the register file. It notes each accepted instruction and
  // queues the read-back that the instruction should produce.
  class alu_mirror;
    logic [VAL_W-1:0] regs [NUM_REGS];
    readback_t        pending_reads [$];
    int unsigned      mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      mismatches = 0;
    endfunction

    function void execute(instr_t ins);
      logic [VAL_W-1:0]        a, b;
      logic signed [VAL_W-1:0] sa, sb;
      readback_t               rb;
      a  = regs[ins.dest_reg];
      b  = regs[ins.src_reg];
      sa = a;
      sb = b;
      case (ins.operation)
        OP_LOAD: regs[ins.dest_reg] = ins.immediate;
        OP_OUT: begin
          rb.read_value = a;
          rb.status     = STATUS_READ;
          pending_reads.push_back(rb);
        end
        OP_MOVE: regs[ins.dest_reg] = b;
        OP_ADD:  regs[ins.dest_reg] = a + b;
        OP_SUB:  regs[ins.dest_reg] = a - b;
        OP_MUL:  regs[ins.dest_reg] = a * b;
        OP_DIV: begin
          if (b == '0) begin
            rb.read_value = '0;
            rb.status     = STATUS_DIV_ZERO;
            pending_reads.push_back(rb);
          end else if (a == MOST_NEGATIVE && b == MINUS_ONE) begin
            regs[ins.dest_reg] = MOST_NEGATIVE;
          end else begin
            regs[ins.dest_reg] = sa / sb;
          end
        end
        default: ;
      endcase
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    function void compare_read(logic [VAL_W-1:0] value, logic status);
      readback_t exp;
      if (pending_reads.size() == 0) begin
        report($sformatf("unexpected result, read_value %h status %b", value, status));
        return;
      end
      exp = pending_reads.pop_front();
      if (value !== exp.read_value)
        report($sformatf("read_value expected %h actual %h", exp.read_value, value));
      if (status !== exp.status)
        report($sformatf("status expected %b actual %b", exp.status, status));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  far_in_if  in_ch ();
  far_out_if out_ch ();

  alu_mirror tracker = new();

  int idle_pct;        // chance, in percent, that either side idles
  bit hold_request;    // ask the receiver for one long hold-off
  int issued;          // instructions sent, ignored operations excluded
  int quiet_cycles = 0;

  always #10 clk = ~clk;

  four_register_alu_machine_core #(
    .DATA_WIDTH(DATA_WIDTH_DEF)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Mostly short gaps, the odd long one, none at all when idle_pct is zero
  function automatic int pick_gap();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(40, 12);
    return $urandom_range(3, 1);
  endfunction

  // Bias operands towards the corners: extremes, small values and zero
  function automatic logic signed [IMM_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return MOST_NEGATIVE;
      1:       return MOST_POSITIVE;
      2:       return MINUS_ONE;
      3, 4, 5: return int'($urandom_range(16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [REG_IDX_W-1:0] pick_reg();
    return REG_IDX_W'($urandom_range(3));
  endfunction

  // Weighted operation mix, with a trickle of the unused code
  function automatic logic [OP_W-1:0] pick_operation();
    int roll;
    roll = $urandom_range(99);
    if (roll < 20) return OP_LOAD;
    if (roll < 45) return OP_OUT;
    if (roll < 53) return OP_MOVE;
    if (roll < 63) return OP_ADD;
    if (roll < 73) return OP_SUB;
    if (roll < 83) return OP_MUL;
    if (roll < 95) return OP_DIV;
    return OP_NONE;
  endfunction

  // Offer one instruction and hold it until accepted, then idle if asked.
  // valid gets one assignment per step: raised here or left high by the
  // previous call, and lowered only before a gap.
  task automatic send(input instr_t ins, input int gap);
    in_ch.valid     <= 1'b1;
    in_ch.operation <= ins.operation;
    in_ch.dest_reg  <= ins.dest_reg;
    in_ch.src_reg   <= ins.src_reg;
    in_ch.immediate <= ins.immediate;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    tracker.execute(ins);
    if (ins.operation != OP_NONE) issued++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic issue(input logic [OP_W-1:0] op, input logic [REG_IDX_W-1:0] dst,
                       input logic [REG_IDX_W-1:0] src, input logic [IMM_W-1:0] imm);
    instr_t ins;
    ins.operation = op;
    ins.dest_reg  = dst;
    ins.src_reg   = src;
    ins.immediate = imm;
    send(ins, pick_gap());
  endtask

  // Load both operands, run one operation on them and read the outcome back
  task automatic run_sequence();
    logic [REG_IDX_W-1:0] dst, src;
    logic [OP_W-1:0]      op;
    dst = pick_reg();
    src = pick_reg();
    case ($urandom_range(4))
      0:       op = OP_MOVE;
      1:       op = OP_ADD;
      2:       op = OP_SUB;
      3:       op = OP_MUL;
      default: op = OP_DIV;
    endcase
    issue(OP_LOAD, dst, pick_reg(), pick_value());
    if (src != dst) issue(OP_LOAD, src, pick_reg(), pick_value());
    issue(op, dst, src, $urandom);
    issue(OP_OUT, dst, pick_reg(), $urandom);
  endtask

  // Drop valid and hold the sender until every read-back has come home
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (tracker.pending_reads.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: reset, a directed pass over the corners, then random phases
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int idle_levels [6];
    int phase;
    idle_levels     = '{0, 30, 60, 15, 45, 0};
    idle_pct        = 30;
    hold_request    = 1'b0;
    issued          = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_LOAD;
    in_ch.dest_reg  <= REG_AX;
    in_ch.src_reg   <= REG_AX;
    in_ch.immediate <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Read every register straight out of reset: all must be zero
    issue(OP_OUT, REG_AX, pick_reg(), $urandom);
    issue(OP_OUT, REG_BX, pick_reg(), $urandom);
    issue(OP_OUT, REG_CX, pick_reg(), $urandom);
    issue(OP_OUT, REG_DX, pick_reg(), $urandom);
    // Load the extremes; the source field is junk and must be ignored
    issue(OP_LOAD, REG_AX, pick_reg(), MOST_POSITIVE);
    issue(OP_LOAD, REG_BX, pick_reg(), MOST_NEGATIVE);
    issue(OP_LOAD, REG_CX, pick_reg(), MINUS_ONE);
    issue(OP_LOAD, REG_DX, pick_reg(), '0);
    // Divide by zero: error read-back, AX left as it was
    issue(OP_DIV, REG_AX, REG_DX, $urandom);
    issue(OP_OUT, REG_AX, pick_reg(), $urandom);
    // Most negative over minus one wraps back to most negative
    issue(OP_MOVE, REG_DX, REG_BX, $urandom);
    issue(OP_DIV, REG_DX, REG_CX, $urandom);
    issue(OP_OUT, REG_DX, pick_reg(), $urandom);
    // Wrap on add and multiply; subtract lands exactly on the most negative value
    issue(OP_ADD, REG_BX, REG_CX, $urandom);
    issue(OP_OUT, REG_BX, pick_reg(), $urandom);
    issue(OP_SUB, REG_CX, REG_AX, $urandom);
    issue(OP_OUT, REG_CX, pick_reg(), $urandom);
    issue(OP_MUL, REG_AX, REG_AX, $urandom);
    issue(OP_OUT, REG_AX, pick_reg(), $urandom);
    // Unused operation code: no effect, no read-back
    issue(OP_NONE, pick_reg(), pick_reg(), $urandom);
    issue(OP_OUT, REG_AX, pick_reg(), $urandom);
    // Signed divide truncates toward zero: -7 / 2 = -3
    issue(OP_LOAD, REG_CX, pick_reg(), -7);
    issue(OP_LOAD, REG_BX, pick_reg(), 2);
    issue(OP_DIV, REG_CX, REG_BX, $urandom);
    issue(OP_OUT, REG_CX, pick_reg(), $urandom);

    // Random phases, each with its own idle level. Phase 2 opens with the
    // long receiver hold-off; phases 3 and 5 open with a full drain.
    issued = 0;
    phase  = -1;
    while (issued < RANDOM_ITEMS) begin
      if (issued / PHASE_LEN != phase) begin
        phase    = issued / PHASE_LEN;
        idle_pct = idle_levels[phase % 6];
        if (phase == 2) hold_request = 1'b1;
        if (phase == 3 || phase == 5) drain_results();
      end
      if ($urandom_range(1) == 0) begin
        run_sequence();
      end else begin
        issue(pick_operation(), pick_reg(), pick_reg(), pick_value());
      end
    end

    // Wait out outstanding read-backs (watchdog bounds this), then linger
    // long enough to catch a stray extra transaction
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_reads.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: check every accepted result, toggle ready at random, and
  // serve the long hold-off in its own cycle count
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int idle_left;
    idle_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.compare_read(out_ch.read_value, out_ch.status);
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (idle_left > 0) begin
        out_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        out_ch.ready <= 1'b1;
        idle_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a transaction on either channel means a hang
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
